FILE: rtl/lzwdt_pkg.sv
// Shared constants, types and codes for the LZW string table.
// Used by the entry RAM and by the lzw_dictionary_table top level.
`default_nettype none

package lzwdt_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ROOT_COUNT  = 256;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W = 12;
  localparam int CHAR_W = 8;
  localparam int MODE_W = 2;

  localparam logic [CNT_W-1:0]  ROOT_CNT   = CNT_W'(ROOT_COUNT);
  localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
  localparam logic [CODE_W:0]   ROOT_LIMIT = (CODE_W + 1)'(ROOT_COUNT);
  localparam logic [CODE_W-1:0] EPC_RESET  = {CODE_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_PAIR   = 2'd0,
    MODE_CODE   = 2'd1,
    MODE_APPEND = 2'd2,
    MODE_REINIT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [CHAR_W-1:0] character;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prefix;
    logic [CHAR_W-1:0] character;
    logic              table_full;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lzw_dictionary_table.sv
// LZW string table top level: control sequencer, root logic and output register.
// Depends on lzwdt_pkg and lzwdt_entry_ram.
//
// Usage: one item per input beat (in_mode, in_prefix, in_character, in_code),
// one result beat per item on the out_ channel. Both channels use valid and
// stall; a beat moves when valid is high and stall is low. The register
// empty_prefix_code is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
// is always high and writes are expected only while the block is idle.
// The root entries are not stored: they are formed from a captured copy of
// empty_prefix_code, so reset and reinitialize take effect at once and no
// clearing pass is needed. Appended entries live in the entry RAM.
// Append, reinitialize and lookups that hit a root go straight to the result
// state, which loads the output register. Other lookups scan the appended
// entries in insertion order, one RAM read per cycle, over at most
// TABLE_DEPTH - ROOT_COUNT appended entries.
// One item is in work at a time; in_stall is high while it is. A finished
// result sits in the output register, so the next item is taken while the
// receiver stalls; the sequencer waits only when a second result is ready.
// Reset empties the table back to the roots and sets empty_prefix_code to 4095.
`default_nettype none

module lzw_dictionary_table
  import lzwdt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [CODE_W-1:0] in_prefix,
  input  wire logic [CHAR_W-1:0] in_character,
  input  wire logic [CODE_W-1:0] in_code,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic [CODE_W-1:0]      out_result_code,
  output logic [CODE_W-1:0]      out_result_prefix,
  output logic [CHAR_W-1:0]      out_result_character,
  output logic                   out_table_full,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CODE_W-1:0] cfg_data
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CODE_W-1:0] root_prefix_r, root_prefix_nxt;
  logic [CODE_W-1:0] epc_r;
  mode_t             req_mode_r, req_mode_nxt;
  entry_t            req_r, req_nxt;
  logic [CNT_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  result_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;

  logic   accept;
  logic   pair_root_hit;
  logic   code_root_hit;
  logic   issue;
  logic   match;
  logic   scan_miss;
  logic   out_free;
  logic   wr_en;
  entry_t wr_data;
  entry_t rd_data;
  mode_t  in_mode_e;

  assign in_mode_e = mode_t'(in_mode);
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign pair_root_hit = (root_prefix_r == in_prefix) &&
                         ((CODE_W + 1)'(in_character) < ROOT_LIMIT);
  assign code_root_hit = ({1'b0, in_code} < ROOT_LIMIT);

  assign issue = (state_r == ST_SCAN) && (rd_addr_r < count_r);
  assign match = cmp_vld_r &&
                 (((req_mode_r == MODE_PAIR) && (rd_data.prefix == req_r.prefix) &&
                   (rd_data.character == req_r.character)) ||
                  ((req_mode_r == MODE_CODE) && (rd_data.code == req_r.code)));
  assign scan_miss = !cmp_vld_r && !issue;

  assign wr_en   = accept && (in_mode_e == MODE_APPEND) && (count_r < DEPTH_CNT);
  assign wr_data = '{prefix: in_prefix, character: in_character, code: in_code};

  lzwdt_entry_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_mode_e == MODE_PAIR && !pair_root_hit) ||
              (in_mode_e == MODE_CODE && !code_root_hit)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (match || scan_miss) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt       = count_r;
    root_prefix_nxt = root_prefix_r;
    req_mode_nxt    = req_mode_r;
    req_nxt         = req_r;
    rd_addr_nxt     = rd_addr_r;
    cmp_vld_nxt     = 1'b0;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_mode_nxt = in_mode_e;
          req_nxt      = wr_data;
          rd_addr_nxt  = ROOT_CNT;
          res_nxt      = '0;
          case (in_mode_e)
            MODE_PAIR: begin
              res_nxt.found = 1'b1;
              res_nxt.code  = CODE_W'(in_character);
            end
            MODE_CODE: begin
              res_nxt.found     = 1'b1;
              res_nxt.code      = in_code;
              res_nxt.prefix    = root_prefix_r;
              res_nxt.character = in_code[CHAR_W-1:0];
            end
            MODE_APPEND: begin
              if (count_r < DEPTH_CNT) begin
                count_nxt     = count_r + CNT_W'(1);
                res_nxt.found = 1'b1;
                res_nxt.code  = in_code;
              end else begin
                res_nxt.table_full = 1'b1;
                res_nxt.code       = epc_r;
              end
            end
            MODE_REINIT: begin
              count_nxt       = ROOT_CNT;
              root_prefix_nxt = epc_r;
            end
            default: res_nxt = '0;
          endcase
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = issue;
        if (issue) begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
        end
        res_nxt = '0;
        if (match) begin
          res_nxt.found = 1'b1;
          if (req_mode_r == MODE_PAIR) begin
            res_nxt.code = rd_data.code;
          end else begin
            res_nxt.code      = req_r.code;
            res_nxt.prefix    = rd_data.prefix;
            res_nxt.character = rd_data.character;
          end
        end else begin
          res_nxt.code = epc_r;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= ROOT_CNT;
      root_prefix_r <= EPC_RESET;
      epc_r         <= EPC_RESET;
      cmp_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      root_prefix_r <= root_prefix_nxt;
      cmp_vld_r     <= cmp_vld_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        epc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_mode_r <= req_mode_nxt;
    req_r      <= req_nxt;
    rd_addr_r  <= rd_addr_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_r.found;
  assign out_result_code      = out_r.code;
  assign out_result_prefix    = out_r.prefix;
  assign out_result_character = out_r.character;
  assign out_table_full       = out_r.table_full;

endmodule

`default_nettype wire

FILE: rtl/lzwdt_entry_ram.sv
// Single-port-write, single-port-read entry RAM with a registered read.
// Depends on lzwdt_pkg for the depth and the entry layout.
`default_nettype none

module lzwdt_entry_ram
  import lzwdt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
